[design/dtep_pkg.sv]
// Shared constants and the CORDIC angle table for the direction-to-pixel pipeline.
package dtep_pkg;

    localparam int DIR_BITS_DEF     = 16;
    localparam int ANGLE_STAGES_DEF = 16;

    localparam int WIDTH_W = 14;
    localparam int COL_W   = 13;
    localparam int ROW_W   = 12;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 14'd1024;
    localparam int COL_MAX = 8191;
    localparam int ROW_MAX = 4095;

    // CORDIC datapath width, angle width, quotient bits and product width.
    localparam int CW = 51;
    localparam int AW = 34;
    localparam int QB = 15;
    localparam int PW = AW + WIDTH_W + 1;
    localparam int WORK_BITS = 48;

    localparam longint PI_Q30       = 64'sd3373259426;
    localparam longint HALF_PI_Q30  = 64'sd1686629713;
    localparam longint TWO_PI_Q30   = 64'sd6746518852;
    localparam longint THREE_HALF_Q30 = 3 * HALF_PI_Q30;

    // atan(2^-i) in radians, Q.30, rounded; from i = 11 on it equals 2^(30-i).
    localparam longint ATAN_TAB [0:10] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
        64'sd4194283,   64'sd2097149,   64'sd1048576
    };

    function automatic longint atan_q30(input int i);
        if (i <= 10) begin
            return ATAN_TAB[i];
        end
        return longint'(1) << (30 - i);
    endfunction

endpackage

[design/direction_to_equirect_pixel.sv]
// Top level: maps a unit direction to an equirectangular panorama column and row.
//
// Takes one direction item per clock and returns one pixel item per clock while its output is
// taken. In order, each item passes the registers that square y and load the root remainder,
// DIR_BITS-2 square-root bit stages, one load plus ANGLE_STAGES CORDIC rotation stages, and
// fifteen quotient bit stages of the pixel divider with multiply, magnitude and clamp stages
// around them. The whole pipeline advances together whenever the output register is empty or
// its item is being taken, so s_axis_tready follows m_axis_tready combinationally. The width
// register may be written at any time through the configuration channel but must only change
// while no item is in flight; the height is half the width.
module direction_to_equirect_pixel #(
    parameter int DIR_BITS     = dtep_pkg::DIR_BITS_DEF,
    parameter int ANGLE_STAGES = dtep_pkg::ANGLE_STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // dir_x, dir_y, dir_z from bit 0 up, zero padded to whole bytes
    input  logic [((3*DIR_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // col, row from bit 0 up, zero padded
    output logic [31:0]                         m_axis_tdata,
    // edge_clamped
    output logic [0:0]                          m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dtep_pkg::WIDTH_W-1:0]        i_cfg_data
);
    import dtep_pkg::*;

    localparam int DB = DIR_BITS;

    logic                 en;
    logic [WIDTH_W-1:0]   r_width;
    logic [WIDTH_W-2:0]   height;
    logic [QB-1:0]        col_limit, row_limit;

    logic                 sq_valid;
    logic [DB-2:0]        sq_s;
    logic signed [DB-1:0] sq_x, sq_y, sq_z;

    logic signed [DB:0]   ph_x, ph_y, th_sx, th_sz, th_x, th_y;
    logic signed [AW-1:0] th_z0;
    logic                 th_neg, th_pos, th_pole;

    logic                 ph_valid, th_valid;
    logic signed [AW-1:0] ph_ang, th_ang;

    logic                 col_valid, row_valid;
    logic [QB-1:0]        col_q, row_q;
    logic                 col_clamp, row_clamp;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_width <= i_cfg_data;
        end
    end

    // A width of zero or one leaves a limit of zero.
    assign height = r_width[WIDTH_W-1:1];
    always_comb begin
        if (r_width == '0) begin
            col_limit = '0;
        end else if (r_width - 1'b1 > WIDTH_W'(COL_MAX)) begin
            col_limit = QB'(COL_MAX);
        end else begin
            col_limit = QB'(r_width - 1'b1);
        end
        if (height == '0) begin
            row_limit = '0;
        end else if (height - 1'b1 > (WIDTH_W-1)'(ROW_MAX)) begin
            row_limit = QB'(ROW_MAX);
        end else begin
            row_limit = QB'(height - 1'b1);
        end
    end

    dtep_sqrt #(.DB(DB)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_x     ($signed(s_axis_tdata[DB-1:0])),
        .i_y     ($signed(s_axis_tdata[2*DB-1:DB])),
        .i_z     ($signed(s_axis_tdata[3*DB-1:2*DB])),
        .o_valid (sq_valid),
        .o_s     (sq_s),
        .o_x     (sq_x),
        .o_y     (sq_y),
        .o_z     (sq_z)
    );

    // Elevation lane: vector (sqrt(1-y^2), y); the lane starts at pi/2 and subtracts.
    assign ph_x = $signed({2'b00, sq_s});
    assign ph_y = {sq_y[DB-1], sq_y};

    // Azimuth lane: fold x into the right half plane and pick the quadrant offset.
    always_comb begin
        th_sx   = {sq_x[DB-1], sq_x};
        th_sz   = {sq_z[DB-1], sq_z};
        th_neg  = sq_x[DB-1];
        th_pos  = !sq_x[DB-1] && (sq_x != '0);
        th_pole = (sq_x == '0) && (sq_z == '0);
        th_x    = th_neg ? -th_sx : th_sx;
        th_y    = th_neg ? -th_sz : th_sz;
        th_z0   = th_pos ? AW'(THREE_HALF_Q30) : AW'(HALF_PI_Q30);
    end

    dtep_cordic #(.DB(DB), .STAGES(ANGLE_STAGES), .NEG_Z(1'b1)) u_cordic_phi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_x     (ph_x),
        .i_y     (ph_y),
        .i_z0    (AW'(HALF_PI_Q30)),
        .i_zero  (1'b0),
        .o_valid (ph_valid),
        .o_z     (ph_ang)
    );

    dtep_cordic #(.DB(DB), .STAGES(ANGLE_STAGES), .NEG_Z(1'b0)) u_cordic_theta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_x     (th_x),
        .i_y     (th_y),
        .i_z0    (th_z0),
        .i_zero  (th_pole),
        .o_valid (th_valid),
        .o_z     (th_ang)
    );

    dtep_pixdiv #(.DIV(TWO_PI_Q30)) u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (th_valid),
        .i_angle (th_ang),
        .i_size  (r_width),
        .i_limit (col_limit),
        .o_valid (col_valid),
        .o_q     (col_q),
        .o_clamp (col_clamp)
    );

    dtep_pixdiv #(.DIV(PI_Q30)) u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ph_valid),
        .i_angle (ph_ang),
        .i_size  ({1'b0, height}),
        .i_limit (row_limit),
        .o_valid (row_valid),
        .o_q     (row_q),
        .o_clamp (row_clamp)
    );

    assign m_axis_tvalid = col_valid;
    assign m_axis_tdata  = {7'b0, row_q[ROW_W-1:0], col_q[COL_W-1:0]};
    assign m_axis_tuser  = col_clamp | row_clamp;

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        col_valid == row_valid)
        else $error("column and row lanes out of step");

    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ph_valid == th_valid)
        else $error("angle lanes out of step");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> col_q <= col_limit)
        else $error("column beyond limit");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> row_q <= row_limit)
        else $error("row beyond limit");

    a_clamp_at_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (col_q == '0 || col_q == col_limit || row_q == '0 || row_q == row_limit))
        else $error("clamp flag without an edge pixel");

endmodule

[design/dtep_sqrt.sv]
// Computes sqrt(1 - y^2) one result bit per stage, carrying the direction alongside.
module dtep_sqrt #(
    parameter int DB = dtep_pkg::DIR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [DB-1:0] i_x,
    input  logic signed [DB-1:0] i_y,
    input  logic signed [DB-1:0] i_z,
    output logic                 o_valid,
    output logic [DB-2:0]        o_s,
    output logic signed [DB-1:0] o_x,
    output logic signed [DB-1:0] o_y,
    output logic signed [DB-1:0] o_z
);
    import dtep_pkg::*;

    localparam int NB = 2 * DB - 4;
    localparam int RB = DB - 2;
    localparam logic [2*DB-1:0] UU = (2*DB)'(1) << NB;

    logic                 r_a_valid;
    logic [2*DB-1:0]      r_ysq;
    logic signed [DB-1:0] r_ax, r_ay, r_az;
    logic signed [2*DB-1:0] n_prod;

    logic                 r_v    [0:RB];
    logic                 r_full [0:RB];
    logic [NB-1:0]        r_rem  [0:RB];
    logic [RB-1:0]        r_root [0:RB];
    logic signed [DB-1:0] r_x    [0:RB];
    logic signed [DB-1:0] r_y    [0:RB];
    logic signed [DB-1:0] r_z    [0:RB];

    assign n_prod = i_y * i_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_v[0]    <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_v[0]    <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ysq     <= n_prod;
            r_ax      <= i_x;
            r_ay      <= i_y;
            r_az      <= i_z;
            // At or beyond unit length the root is zero.
            r_rem[0]  <= (r_ysq < UU) ? NB'(UU - r_ysq) : '0;
            // With y at zero the root is exactly one, which the bit stages cannot hold.
            r_full[0] <= (r_ysq == '0);
            r_root[0] <= '0;
            r_x[0]    <= r_ax;
            r_y[0]    <= r_ay;
            r_z[0]    <= r_az;
        end
    end

    for (genvar j = 0; j < RB; j++) begin : g_bit
        localparam int K = RB - 1 - j;
        logic [NB+1:0] trial;
        logic          take;

        always_comb begin
            trial = ((NB+2)'(r_root[j]) << (K + 1)) + ((NB+2)'(1) << (2 * K));
            take  = {2'b00, r_rem[j]} >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= take ? NB'({2'b00, r_rem[j]} - trial) : r_rem[j];
                r_root[j+1] <= take ? (r_root[j] | (RB'(1) << K)) : r_root[j];
                r_full[j+1] <= r_full[j];
                r_x[j+1]    <= r_x[j];
                r_y[j+1]    <= r_y[j];
                r_z[j+1]    <= r_z[j];
            end
        end
    end

    assign o_valid = r_v[RB];
    assign o_s     = r_full[RB] ? ((DB-1)'(1) << RB) : {1'b0, r_root[RB]};
    assign o_x     = r_x[RB];
    assign o_y     = r_y[RB];
    assign o_z     = r_z[RB];

endmodule

[design/dtep_cordic.sv]
// Vectoring CORDIC lane, one rotation per register stage, accumulating the angle.
module dtep_cordic #(
    parameter int DB     = dtep_pkg::DIR_BITS_DEF,
    parameter int STAGES = dtep_pkg::ANGLE_STAGES_DEF,
    parameter bit NEG_Z  = 1'b0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic signed [DB:0]               i_x,
    input  logic signed [DB:0]               i_y,
    input  logic signed [dtep_pkg::AW-1:0]   i_z0,
    input  logic                             i_zero,
    output logic                             o_valid,
    output logic signed [dtep_pkg::AW-1:0]   o_z
);
    import dtep_pkg::*;

    localparam int WS = WORK_BITS - DB;

    logic                 r_v    [0:STAGES];
    logic                 r_zero [0:STAGES];
    logic signed [CW-1:0] r_x    [0:STAGES];
    logic signed [CW-1:0] r_y    [0:STAGES];
    logic signed [AW-1:0] r_z    [0:STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= CW'(i_x) <<< WS;
            r_y[0]    <= CW'(i_y) <<< WS;
            r_z[0]    <= i_z0;
            r_zero[0] <= i_zero;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        localparam logic signed [AW-1:0] A = AW'(atan_q30(i));
        logic signed [CW-1:0] dx, dy, n_x, n_y;
        logic signed [AW-1:0] n_z;
        logic                 up;

        always_comb begin
            dx = r_y[i] >>> i;
            dy = r_x[i] >>> i;
            up = !r_y[i][CW-1];
            n_x = up ? r_x[i] + dx : r_x[i] - dx;
            n_y = up ? r_y[i] - dy : r_y[i] + dy;
            n_z = (up ^ NEG_Z) ? r_z[i] + A : r_z[i] - A;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]    <= n_x;
                r_y[i+1]    <= n_y;
                r_z[i+1]    <= n_z;
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_z     = r_zero[STAGES] ? '0 : r_z[STAGES];

endmodule

[design/dtep_pixdiv.sv]
// Scales an angle by the image size and divides by a constant span, one quotient bit per stage.
module dtep_pixdiv #(
    parameter longint DIV = dtep_pkg::TWO_PI_Q30
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [dtep_pkg::AW-1:0]     i_angle,
    input  logic [dtep_pkg::WIDTH_W-1:0]       i_size,
    input  logic [dtep_pkg::QB-1:0]            i_limit,
    output logic                               o_valid,
    output logic [dtep_pkg::QB-1:0]            o_q,
    output logic                               o_clamp
);
    import dtep_pkg::*;

    logic                 r_m_valid, r_s_valid;
    logic signed [PW-1:0] r_p;
    logic signed [PW-1:0] n_p;
    logic                 r_neg [0:QB];
    logic                 r_v   [0:QB];
    logic [PW-1:0]        r_rem [0:QB];
    logic [QB-1:0]        r_q   [0:QB];
    logic                 r_o_valid;
    logic [QB-1:0]        r_o_q;
    logic                 r_o_clamp;

    assign n_p = $signed({1'b0, i_size}) * i_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_v[0]    <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_m_valid <= i_valid;
            r_v[0]    <= r_m_valid;
            r_o_valid <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p      <= n_p;
            r_neg[0] <= r_p[PW-1];
            r_rem[0] <= r_p[PW-1] ? PW'(-r_p) : PW'(r_p);
            r_q[0]   <= '0;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_qbit
        localparam int K = QB - 1 - j;
        localparam logic [PW:0] DK = (PW+1)'(DIV) << K;
        logic take;

        assign take = {1'b0, r_rem[j]} >= DK;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= take ? PW'({1'b0, r_rem[j]} - DK) : r_rem[j];
                r_q[j+1]   <= take ? (r_q[j] | (QB'(1) << K)) : r_q[j];
                r_neg[j+1] <= r_neg[j];
            end
        end
    end

    // A negative product truncates toward zero, so only a quotient of one or more clamps.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[QB] && r_q[QB] != '0) begin
                r_o_q     <= '0;
                r_o_clamp <= 1'b1;
            end else if (!r_neg[QB] && r_q[QB] > i_limit) begin
                r_o_q     <= i_limit;
                r_o_clamp <= 1'b1;
            end else begin
                r_o_q     <= r_neg[QB] ? '0 : r_q[QB];
                r_o_clamp <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_q     = r_o_q;
    assign o_clamp = r_o_clamp;

endmodule
